@@ hdl/segment_intersection_test_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection test core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH

// Same-cycle implication
`define SIT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment intersection core: implication check failed");

// Next-cycle implication
`define SIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment intersection core: next-cycle check failed");

`endif

@@ hdl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared widths and types for the segment intersection test pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sit_pkg;

    localparam int COORD_W = 15;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_val_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // Direction and offset vectors of the two segments
    typedef struct packed {
        diff_val_t rx;
        diff_val_t ry;
        diff_val_t sx;
        diff_val_t sy;
        diff_val_t qx;
        diff_val_t qy;
    } diff_t;

    // Cross products r x s, q x s, q x r
    typedef struct packed {
        prod_t rxs;
        prod_t tt;
        prod_t ut;
    } cross_t;

endpackage

@@ hdl/segment_intersection_test_core.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Tests whether the open interiors of two integer segments cross.
// ----------------------------------------------------------------------------
// A segment pair is taken on every cycle that start is high; busy is never
// raised. The flag appears on crosses with done high exactly four cycles
// later, for one cycle, and must be captured then. The four stages are:
// vector differences and per-axis intervals, the product stage of the cross
// product unit, the cross differences with the collinear overlap test, and
// the final sign and range compare against r x s.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "segment_intersection_test_core_assert.svh"

module segment_intersection_test_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  sit_pkg::coord_t        a_start_x,
    input  sit_pkg::coord_t        a_start_y,
    input  sit_pkg::coord_t        a_end_x,
    input  sit_pkg::coord_t        a_end_y,
    input  sit_pkg::coord_t        b_start_x,
    input  sit_pkg::coord_t        b_start_y,
    input  sit_pkg::coord_t        b_end_x,
    input  sit_pkg::coord_t        b_end_y,
    output logic                   done,
    output logic                   crosses
);

    typedef struct packed {
        sit_pkg::coord_t a_lo;
        sit_pkg::coord_t a_hi;
        sit_pkg::coord_t b_lo;
        sit_pkg::coord_t b_hi;
    } span_t;

    // Valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1
    sit_pkg::diff_t diff_reg, diff_next;
    span_t          span_x1_reg, span_y1_reg, span_x1_next, span_y1_next;
    logic           degen1_reg, degen1_next;

    // Stage 2
    span_t              span_x2_reg, span_y2_reg;
    sit_pkg::diff_val_t ext_x2_reg, ext_y2_reg, ext_x2_next, ext_y2_next;
    logic               degen2_reg;

    // Stage 3
    logic overlap3_reg, overlap3_next;
    logic degen3_reg;
    sit_pkg::cross_t cross3;
    span_t span_sel;

    // Stage 4
    logic crosses_reg, crosses_next;

    // Input differences, degenerate check and per-axis intervals
    always_comb
    begin
        diff_next.rx = sit_pkg::diff_val_t'(a_end_x)   - sit_pkg::diff_val_t'(a_start_x);
        diff_next.ry = sit_pkg::diff_val_t'(a_end_y)   - sit_pkg::diff_val_t'(a_start_y);
        diff_next.sx = sit_pkg::diff_val_t'(b_end_x)   - sit_pkg::diff_val_t'(b_start_x);
        diff_next.sy = sit_pkg::diff_val_t'(b_end_y)   - sit_pkg::diff_val_t'(b_start_y);
        diff_next.qx = sit_pkg::diff_val_t'(b_start_x) - sit_pkg::diff_val_t'(a_start_x);
        diff_next.qy = sit_pkg::diff_val_t'(b_start_y) - sit_pkg::diff_val_t'(a_start_y);
        degen1_next = ((a_start_x == a_end_x) && (a_start_y == a_end_y)) ||
                      ((b_start_x == b_end_x) && (b_start_y == b_end_y));
        span_x1_next.a_lo = (a_start_x < a_end_x) ? a_start_x : a_end_x;
        span_x1_next.a_hi = (a_start_x < a_end_x) ? a_end_x : a_start_x;
        span_x1_next.b_lo = (b_start_x < b_end_x) ? b_start_x : b_end_x;
        span_x1_next.b_hi = (b_start_x < b_end_x) ? b_end_x : b_start_x;
        span_y1_next.a_lo = (a_start_y < a_end_y) ? a_start_y : a_end_y;
        span_y1_next.a_hi = (a_start_y < a_end_y) ? a_end_y : a_start_y;
        span_y1_next.b_lo = (b_start_y < b_end_y) ? b_start_y : b_end_y;
        span_y1_next.b_hi = (b_start_y < b_end_y) ? b_end_y : b_start_y;
    end

    // Extent of all four points along each axis
    always_comb
    begin
        ext_x2_next =
            sit_pkg::diff_val_t'((span_x1_reg.a_hi > span_x1_reg.b_hi) ?
                                 span_x1_reg.a_hi : span_x1_reg.b_hi) -
            sit_pkg::diff_val_t'((span_x1_reg.a_lo < span_x1_reg.b_lo) ?
                                 span_x1_reg.a_lo : span_x1_reg.b_lo);
        ext_y2_next =
            sit_pkg::diff_val_t'((span_y1_reg.a_hi > span_y1_reg.b_hi) ?
                                 span_y1_reg.a_hi : span_y1_reg.b_hi) -
            sit_pkg::diff_val_t'((span_y1_reg.a_lo < span_y1_reg.b_lo) ?
                                 span_y1_reg.a_lo : span_y1_reg.b_lo);
    end

    // Pick the dominant axis (y on a tie) and test open-interval overlap
    always_comb
    begin
        span_sel = (ext_x2_reg > ext_y2_reg) ? span_x2_reg : span_y2_reg;
        overlap3_next =
            ((span_sel.a_lo == span_sel.b_lo) && (span_sel.a_hi == span_sel.b_hi)) ||
            ((span_sel.b_lo > span_sel.a_lo) && (span_sel.b_lo < span_sel.a_hi)) ||
            ((span_sel.b_hi > span_sel.a_lo) && (span_sel.b_hi < span_sel.a_hi)) ||
            ((span_sel.a_lo > span_sel.b_lo) && (span_sel.a_lo < span_sel.b_hi)) ||
            ((span_sel.a_hi > span_sel.b_lo) && (span_sel.a_hi < span_sel.b_hi));
    end

    // Cross product unit covers stages two and three
    sit_cross u_cross
    (
        .clk          (clk),
        .diffs        (diff_reg),
        .crosses_term (cross3)
    );

    // Place the crossing strictly inside both segments, or use the collinear overlap; degenerate pairs never cross
    always_comb
    begin
        if (degen3_reg)
        begin
            crosses_next = 1'b0;
        end
        else if (cross3.rxs > 0)
        begin
            crosses_next = (cross3.tt > 0) && (cross3.tt < cross3.rxs) &&
                           (cross3.ut > 0) && (cross3.ut < cross3.rxs);
        end
        else if (cross3.rxs < 0)
        begin
            crosses_next = (cross3.tt < 0) && (cross3.tt > cross3.rxs) &&
                           (cross3.ut < 0) && (cross3.ut > cross3.rxs);
        end
        else
        begin
            crosses_next = (cross3.tt == 0) && (cross3.ut == 0) && overlap3_reg;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            crosses_reg <= 1'b0;
        end
        else
        begin
            v1_reg      <= start;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            crosses_reg <= v3_reg && crosses_next;
        end
    end

    // Advance payload every cycle
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        span_x1_reg  <= span_x1_next;
        span_y1_reg  <= span_y1_next;
        degen1_reg   <= degen1_next;
        span_x2_reg  <= span_x1_reg;
        span_y2_reg  <= span_y1_reg;
        ext_x2_reg   <= ext_x2_next;
        ext_y2_reg   <= ext_y2_next;
        degen2_reg   <= degen1_reg;
        overlap3_reg <= overlap3_next;
        degen3_reg   <= degen2_reg;
    end

    assign busy    = 1'b0;
    assign done    = v4_reg;
    assign crosses = crosses_reg;

    // A result only comes out for an accepted transfer
    `SIT_ASSERT_IMPLY(a_done_latency, done, $past(start, 4))
    // The flag is only raised with its strobe
    `SIT_ASSERT_IMPLY(a_flag_with_done, crosses, done)
    // A degenerate segment never yields a crossing
    `SIT_ASSERT_NEXT(a_degen_clear, v3_reg && degen3_reg, !crosses)

endmodule

@@ hdl/sit_cross.sv @@
// ----------------------------------------------------------------------------
// sit_cross
// Two-stage cross product unit: six registered products, then registered
// differences giving r x s, q x s and q x r.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sit_cross
(
    input  logic           clk,
    input  sit_pkg::diff_t diffs,
    output sit_pkg::cross_t crosses_term
);

    sit_pkg::prod_t rx_sy_reg, ry_sx_reg, qx_sy_reg, qy_sx_reg, qx_ry_reg, qy_rx_reg;
    sit_pkg::prod_t rx_sy_next, ry_sx_next, qx_sy_next, qy_sx_next, qx_ry_next, qy_rx_next;
    sit_pkg::cross_t cross_reg, cross_next;

    // Form the six products
    always_comb
    begin
        rx_sy_next = sit_pkg::prod_t'(diffs.rx) * sit_pkg::prod_t'(diffs.sy);
        ry_sx_next = sit_pkg::prod_t'(diffs.ry) * sit_pkg::prod_t'(diffs.sx);
        qx_sy_next = sit_pkg::prod_t'(diffs.qx) * sit_pkg::prod_t'(diffs.sy);
        qy_sx_next = sit_pkg::prod_t'(diffs.qy) * sit_pkg::prod_t'(diffs.sx);
        qx_ry_next = sit_pkg::prod_t'(diffs.qx) * sit_pkg::prod_t'(diffs.ry);
        qy_rx_next = sit_pkg::prod_t'(diffs.qy) * sit_pkg::prod_t'(diffs.rx);
    end

    // Subtract product pairs; magnitudes stay below 2^31
    always_comb
    begin
        cross_next.rxs = rx_sy_reg - ry_sx_reg;
        cross_next.tt  = qx_sy_reg - qy_sx_reg;
        cross_next.ut  = qx_ry_reg - qy_rx_reg;
    end

    // Advance payload every cycle
    always_ff @(posedge clk)
    begin
        rx_sy_reg <= rx_sy_next;
        ry_sx_reg <= ry_sx_next;
        qx_sy_reg <= qx_sy_next;
        qy_sx_reg <= qy_sx_next;
        qx_ry_reg <= qx_ry_next;
        qy_rx_reg <= qy_rx_next;
        cross_reg <= cross_next;
    end

    assign crosses_term = cross_reg;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the segment intersection core. Each segment pair sent into the core
// is run through a behavioral model that works out the crossing flag. The
// flag is queued until the core strobes done, and then compared with it.
// A short directed list covers the corner cases: degenerate segments, end
// point touches, parallel and collinear pairs, and extreme coordinates.
// Random pairs follow, most of them built to be collinear, touching or
// nearly so. The sender idles in random bursts and five times waits for the
// pipeline to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_PAIRS = 650;
    localparam int TAIL_PAIRS   = 60;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_LIMIT  = 200;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        sit_pkg::coord_t a_start_x;
        sit_pkg::coord_t a_start_y;
        sit_pkg::coord_t a_end_x;
        sit_pkg::coord_t a_end_y;
        sit_pkg::coord_t b_start_x;
        sit_pkg::coord_t b_start_y;
        sit_pkg::coord_t b_end_x;
        sit_pkg::coord_t b_end_y;
        bit              wait_drain;
    } seg_pair_t;

    typedef struct {
        bit        crosses;
        seg_pair_t pair;
    } crossing_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    logic      done;
    logic      crosses;
    seg_pair_t drive_pair = '{default: '0};

    seg_pair_t pairs_to_send[$];
    crossing_t flags_in_flight[$];
    int        mismatch_count = 0;
    bit        last_xfer = 1'b0;
    int        gap_left = 0;
    int        calm_left = 0;

    segment_intersection_test_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .a_start_x (drive_pair.a_start_x),
        .a_start_y (drive_pair.a_start_y),
        .a_end_x   (drive_pair.a_end_x),
        .a_end_y   (drive_pair.a_end_y),
        .b_start_x (drive_pair.b_start_x),
        .b_start_y (drive_pair.b_start_y),
        .b_end_x   (drive_pair.b_end_x),
        .b_end_y   (drive_pair.b_end_y),
        .done      (done),
        .crosses   (crosses)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold reset, release on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Crossing flag of two segments: strict interior crossing for
    // non-parallel pairs, open-interval overlap along the longer axis
    // for collinear pairs
    function automatic bit predict_crossing(seg_pair_t p);
        longint x[4];
        longint y[4];
        longint u[4];
        longint rx, ry, sx, sy, qx, qy, rxs, tt, ut;
        longint x_lo, x_hi, y_lo, y_hi, a_lo, a_hi, b_lo, b_hi;
        x[0] = longint'(p.a_start_x);
        y[0] = longint'(p.a_start_y);
        x[1] = longint'(p.a_end_x);
        y[1] = longint'(p.a_end_y);
        x[2] = longint'(p.b_start_x);
        y[2] = longint'(p.b_start_y);
        x[3] = longint'(p.b_end_x);
        y[3] = longint'(p.b_end_y);

        // A point is not a segment
        if ((x[0] == x[1] && y[0] == y[1]) || (x[2] == x[3] && y[2] == y[3]))
            return 1'b0;

        rx  = x[1] - x[0];
        ry  = y[1] - y[0];
        sx  = x[3] - x[2];
        sy  = y[3] - y[2];
        qx  = x[2] - x[0];
        qy  = y[2] - y[0];
        rxs = rx * sy - ry * sx;
        tt  = qx * sy - qy * sx;
        ut  = qx * ry - qy * rx;

        if (rxs > 0)
            return tt > 0 && tt < rxs && ut > 0 && ut < rxs;
        if (rxs < 0)
            return tt < 0 && tt > rxs && ut < 0 && ut > rxs;
        if (tt != 0 || ut != 0)
            return 1'b0;

        // Collinear: project onto the axis with the larger extent, y on a tie
        x_lo = x[0]; x_hi = x[0]; y_lo = y[0]; y_hi = y[0];
        for (int i = 1; i < 4; i++)
        begin
            if (x[i] < x_lo) x_lo = x[i];
            if (x[i] > x_hi) x_hi = x[i];
            if (y[i] < y_lo) y_lo = y[i];
            if (y[i] > y_hi) y_hi = y[i];
        end
        for (int i = 0; i < 4; i++)
            u[i] = (x_hi - x_lo > y_hi - y_lo) ? x[i] : y[i];

        a_lo = (u[0] < u[1]) ? u[0] : u[1];
        a_hi = (u[0] < u[1]) ? u[1] : u[0];
        b_lo = (u[2] < u[3]) ? u[2] : u[3];
        b_hi = (u[2] < u[3]) ? u[3] : u[2];
        return (a_lo == b_lo && a_hi == b_hi) ||
               (b_lo > a_lo && b_lo < a_hi) ||
               (b_hi > a_lo && b_hi < a_hi) ||
               (a_lo > b_lo && a_lo < b_hi) ||
               (a_hi > b_lo && a_hi < b_hi);
    endfunction

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int extreme_coord();
        int picks[7] = '{-16384, -16383, -1, 0, 1, 16382, 16383};
        return picks[$urandom_range(0, 6)];
    endfunction

    task automatic add_pair(input int ax0, input int ay0, input int ax1, input int ay1,
                            input int bx0, input int by0, input int bx1, input int by1,
                            input bit hold);
        seg_pair_t p;
        p.a_start_x  = sit_pkg::coord_t'(ax0);
        p.a_start_y  = sit_pkg::coord_t'(ay0);
        p.a_end_x    = sit_pkg::coord_t'(ax1);
        p.a_end_y    = sit_pkg::coord_t'(ay1);
        p.b_start_x  = sit_pkg::coord_t'(bx0);
        p.b_start_y  = sit_pkg::coord_t'(by0);
        p.b_end_x    = sit_pkg::coord_t'(bx1);
        p.b_end_y    = sit_pkg::coord_t'(by1);
        p.wait_drain = hold;
        pairs_to_send = {pairs_to_send, p};
    endtask

    // Fill the send queue, then wait for the last flag and report
    initial
    begin
        int px, py, dx, dy, t0, t1, t2, t3, tm, ox, oy;
        int guard;
        bit hold;

        // Crossings in both orientations, including corner to corner, then a parallel miss
        add_pair(-10, -10, 10, 10, -10, 10, 10, -10, 1'b0);
        add_pair(-10, 10, 10, -10, -10, -10, 10, 10, 1'b0);
        add_pair(-16384, -16384, 16383, 16383, -16384, 16383, 16383, -16384, 1'b0);
        add_pair(-16384, 16383, 16383, -16384, 16383, 16383, -16384, -16384, 1'b0);
        add_pair(-16384, -16384, 16383, 16382, -16384, -16383, 16383, 16383, 1'b0);
        // Degenerate segments
        add_pair(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, 1'b0);
        add_pair(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383, 1'b0);
        add_pair(0, 0, 0, 0, -5, 0, 5, 0, 1'b0);
        add_pair(-5, 0, 5, 0, 0, 0, 0, 0, 1'b0);
        // Touching at an end point
        add_pair(0, 0, 10, 0, 10, 0, 10, 10, 1'b0);
        add_pair(0, 0, 10, 0, 5, 0, 5, 10, 1'b0);
        add_pair(5, -10, 5, 0, 0, 0, 10, 0, 1'b0);
        // Parallel, not collinear; wait for the pipeline to empty first
        add_pair(0, 0, 10, 0, 0, 1, 10, 1, 1'b1);
        add_pair(0, 0, 10, 10, 1, 0, 11, 10, 1'b0);
        // Lines cross outside the segments
        add_pair(0, 0, 10, 0, 20, -5, 20, 5, 1'b0);
        // Collinear: overlap, disjoint, end touch, identical, contained
        add_pair(0, 0, 10, 0, 5, 0, 15, 0, 1'b0);
        add_pair(0, 0, 10, 0, 20, 0, 30, 0, 1'b0);
        add_pair(0, 0, 10, 0, 10, 0, 20, 0, 1'b0);
        add_pair(0, 0, 10, 0, 0, 0, 10, 0, 1'b0);
        add_pair(0, 0, 10, 0, 10, 0, 0, 0, 1'b0);
        add_pair(0, 0, 10, 0, 0, 0, 5, 0, 1'b0);
        add_pair(3, -16384, 3, 16383, 3, 0, 3, 100, 1'b0);
        add_pair(0, 0, 8, 8, 4, 4, 12, 12, 1'b0);
        add_pair(0, 0, 8, 4, 8, 4, 16, 8, 1'b0);
        add_pair(-16384, 16383, 16383, 16383, 16383, 16383, -16384, 16383, 1'b0);

        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            hold = (n % 150 == 75);
            // Points on one line, small or large steps
            px = rnd(-2000, 2000);
            py = rnd(-2000, 2000);
            if ($urandom_range(0, 3) == 0)
            begin
                dx = rnd(-300, 300);
                dy = rnd(-300, 300);
            end
            else
            begin
                dx = rnd(-40, 40);
                dy = rnd(-40, 40);
            end
            case ($urandom_range(0, 4))
                0: dy = 0;
                1: dx = 0;
                default: ;
            endcase
            t0 = rnd(-40, 40);
            t1 = rnd(-40, 40);
            t2 = rnd(-40, 40);
            t3 = rnd(-40, 40);

            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    add_pair(px + t0 * dx, py + t0 * dy, px + t1 * dx, py + t1 * dy,
                             px + t2 * dx, py + t2 * dy, px + t3 * dx, py + t3 * dy, hold);
                end
                3, 4:
                begin
                    px = rnd(-16000, 16000);
                    py = rnd(-16000, 16000);
                    add_pair(px + rnd(-4, 4), py + rnd(-4, 4), px + rnd(-4, 4), py + rnd(-4, 4),
                             px + rnd(-4, 4), py + rnd(-4, 4), px + rnd(-4, 4), py + rnd(-4, 4),
                             hold);
                end
                5:
                begin
                    // Shift a copy of the line sideways by a small offset
                    ox = rnd(-3, 3);
                    oy = rnd(-3, 3);
                    add_pair(px + t0 * dx, py + t0 * dy, px + t1 * dx, py + t1 * dy,
                             px + t2 * dx + ox, py + t2 * dy + oy,
                             px + t3 * dx + ox, py + t3 * dy + oy, hold);
                end
                6:
                begin
                    // Put one end of one segment on the other, at an end or inside
                    tm = (t0 < t1) ? rnd(t0, t1) : rnd(t1, t0);
                    ox = px + tm * dx;
                    oy = py + tm * dy;
                    if ($urandom_range(0, 1) == 0)
                        add_pair(px + t0 * dx, py + t0 * dy, px + t1 * dx, py + t1 * dy,
                                 ox, oy, ox + rnd(-50, 50), oy + rnd(-50, 50), hold);
                    else
                        add_pair(ox + rnd(-50, 50), oy + rnd(-50, 50), ox, oy,
                                 px + t0 * dx, py + t0 * dy, px + t1 * dx, py + t1 * dy,
                                 hold);
                end
                7:
                begin
                    add_pair(extreme_coord(), extreme_coord(), extreme_coord(),
                             extreme_coord(), extreme_coord(), extreme_coord(),
                             extreme_coord(), extreme_coord(), hold);
                end
                default:
                begin
                    add_pair(rnd(-16384, 16383), rnd(-16384, 16383), rnd(-16384, 16383),
                             rnd(-16384, 16383), rnd(-16384, 16383), rnd(-16384, 16383),
                             rnd(-16384, 16383), rnd(-16384, 16383), hold);
                end
            endcase
        end

        // Wait for the last transfer, then for the last flag
        @(posedge rst_n);
        while (pairs_to_send.size() != 0 || start)
            @(posedge clk);
        guard = 0;
        while (flags_in_flight.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (flags_in_flight.size() != 0)
        begin
            mismatch_count += flags_in_flight.size();
            $display("%0d crossing flags never came out", flags_in_flight.size());
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Driver: present the next pair on the falling edge once the current
    // one has been taken; idle in random bursts except near the end
    always @(negedge clk)
    begin
        seg_pair_t nxt;
        bit        send;
        send = 1'b0;
        nxt  = drive_pair;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || last_xfer)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pairs_to_send.size() != 0)
            begin
                if (pairs_to_send[0].wait_drain && flags_in_flight.size() != 0)
                begin
                    // hold until every flag in flight has come out
                end
                else if (pairs_to_send.size() > TAIL_PAIRS && calm_left == 0 &&
                         $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 10);
                    if ($urandom_range(0, 3) == 0)
                        calm_left = $urandom_range(10, 60);
                end
                else
                begin
                    nxt  = pairs_to_send.pop_front();
                    send = 1'b1;
                    if (calm_left > 0)
                        calm_left--;
                end
            end
            start      <= send;
            drive_pair <= nxt;
        end
    end

    // Monitor: check each done strobe against the oldest expected flag,
    // then queue the flag for a pair transferred at this edge
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (flags_in_flight.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("done strobe with no pair in flight, crosses=%0b", crosses);
                end
                else
                begin
                    want = flags_in_flight.pop_front();
                    if (crosses !== want.crosses)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("crosses mismatch A (%0d,%0d)-(%0d,%0d) B (%0d,%0d)-(%0d,%0d): expected %0b got %0b",
                                     want.pair.a_start_x, want.pair.a_start_y,
                                     want.pair.a_end_x, want.pair.a_end_y,
                                     want.pair.b_start_x, want.pair.b_start_y,
                                     want.pair.b_end_x, want.pair.b_end_y,
                                     want.crosses, crosses);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                want.pair    = drive_pair;
                want.crosses = predict_crossing(drive_pair);
                flags_in_flight = {flags_in_flight, want};
            end
        end
        last_xfer = rst_n && start === 1'b1 && busy === 1'b0;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/sit_pkg.sv
hdl/sit_cross.sv
hdl/segment_intersection_test_core.sv
bench/tb_top.sv
